// ----- rtl/core/lavm_pkg.sv -----
`timescale 1ns / 1ps

package lavm_pkg;

    localparam int NORM_LAT  = 70;
    localparam int CROSS_LAT = 2;
    localparam int XLATE_LAT = 3;

    localparam logic [5:0] LEAD_TARGET = 6'd30;

    typedef logic [2:0][31:0] t_vec3;
    typedef logic [2:0][63:0] t_wvec3;

    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/core/lavm_cross.sv -----
`timescale 1ns / 1ps

module lavm_cross #(
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lavm_pkg::t_vec3      i_a,
    input  lavm_pkg::t_vec3      i_b,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output lavm_pkg::t_wvec3     o_c,
    output logic [SIDE_W-1:0]    o_side
);
    import lavm_pkg::*;

    logic                     r_vld;
    logic signed [63:0]       r_prod [6];
    logic [SIDE_W-1:0]        r_side;
    logic                     r_out_vld;
    t_wvec3                   r_c;
    logic [SIDE_W-1:0]        r_out_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= i_valid;
            r_out_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod[0]  <= $signed(i_a[1]) * $signed(i_b[2]);
        r_prod[1]  <= $signed(i_a[2]) * $signed(i_b[1]);
        r_prod[2]  <= $signed(i_a[2]) * $signed(i_b[0]);
        r_prod[3]  <= $signed(i_a[0]) * $signed(i_b[2]);
        r_prod[4]  <= $signed(i_a[0]) * $signed(i_b[1]);
        r_prod[5]  <= $signed(i_a[1]) * $signed(i_b[0]);
        r_side     <= i_side;
        r_c[0]     <= r_prod[0] - r_prod[1];
        r_c[1]     <= r_prod[2] - r_prod[3];
        r_c[2]     <= r_prod[4] - r_prod[5];
        r_out_side <= r_side;
    end

    assign o_valid = r_out_vld;
    assign o_c     = r_c;
    assign o_side  = r_out_side;

endmodule

// ----- rtl/core/lavm_norm.sv -----
`timescale 1ns / 1ps

module lavm_norm #(
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lavm_pkg::t_wvec3     i_vec,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output lavm_pkg::t_vec3      o_unit,
    output logic [SIDE_W-1:0]    o_side
);
    import lavm_pkg::*;

    // Front end: magnitude, leading one, common shift, squares.
    logic                  r1_vld, r2_vld, r3_vld, r4_vld;
    logic [2:0][63:0]      r1_mag, r2_mag;
    logic [2:0]            r1_neg, r2_neg, r3_neg, r4_neg;
    logic [SIDE_W-1:0]     r1_side, r2_side, r3_side, r4_side;
    logic [5:0]            r2_lead;
    logic                  r2_zero, r3_zero, r4_zero;
    logic [2:0][30:0]      r3_m, r4_m;
    logic [2:0][61:0]      r4_sq;

    // Square root pipeline, one root bit per stage.
    logic                  r_sq_vld  [33];
    logic [63:0]           r_sq_s    [33];
    logic [34:0]           r_sq_rem  [33];
    logic [31:0]           r_sq_root [33];
    logic [2:0][30:0]      r_sq_m    [33];
    logic [2:0]            r_sq_neg  [33];
    logic                  r_sq_zero [33];
    logic [SIDE_W-1:0]     r_sq_side [33];

    // Divider pipeline, one quotient bit per stage for all three components.
    logic                  r_dv_vld  [32];
    logic [2:0][31:0]      r_dv_rem  [32];
    logic [2:0][30:0]      r_dv_low  [32];
    logic [2:0][30:0]      r_dv_quo  [32];
    logic [31:0]           r_dv_len  [32];
    logic [2:0]            r_dv_neg  [32];
    logic                  r_dv_zero [32];
    logic [SIDE_W-1:0]     r_dv_side [32];

    logic                  r_out_vld;
    t_vec3                 r_out_unit;
    logic [SIDE_W-1:0]     r_out_side;

    logic [2:0][61:0]      n_num;
    logic [5:0]            n_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r_sq_vld[0] <= 1'b0;
        end else begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r_sq_vld[0] <= r4_vld;
        end
    end

    always_comb begin
        if (r2_lead > LEAD_TARGET) begin
            n_shift = r2_lead - LEAD_TARGET;
        end else begin
            n_shift = LEAD_TARGET - r2_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_neg[i] <= i_vec[i][63];
            r1_mag[i] <= i_vec[i][63] ? (64'd0 - i_vec[i]) : i_vec[i];
        end
        r1_side <= i_side;

        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_side <= r1_side;
        r2_lead <= lead_one(r1_mag[0] | r1_mag[1] | r1_mag[2]);
        r2_zero <= ((r1_mag[0] | r1_mag[1] | r1_mag[2]) == 64'd0);

        for (int i = 0; i < 3; i++) begin
            if (r2_lead > LEAD_TARGET) begin
                r3_m[i] <= 31'(r2_mag[i] >> n_shift);
            end else begin
                r3_m[i] <= 31'(r2_mag[i] << n_shift);
            end
        end
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        r3_side <= r2_side;

        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= r3_m[i] * r3_m[i];
        end
        r4_m    <= r3_m;
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_side <= r3_side;

        r_sq_s[0]    <= {2'b00, r4_sq[0]} + {2'b00, r4_sq[1]} + {2'b00, r4_sq[2]};
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_m[0]    <= r4_m;
        r_sq_neg[0]  <= r4_neg;
        r_sq_zero[0] <= r4_zero;
        r_sq_side[0] <= r4_side;
    end

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        logic [36:0] w_cur;
        logic [36:0] w_trial;

        assign w_cur   = {r_sq_rem[k][33:0], r_sq_s[k][63:62], 1'b0} >> 1;
        assign w_trial = {3'b000, r_sq_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_cur >= w_trial) begin
                r_sq_rem[k+1]  <= 35'(w_cur - w_trial);
                r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b1};
            end else begin
                r_sq_rem[k+1]  <= w_cur[34:0];
                r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b0};
            end
            r_sq_s[k+1]    <= {r_sq_s[k][61:0], 2'b00};
            r_sq_m[k+1]    <= r_sq_m[k];
            r_sq_neg[k+1]  <= r_sq_neg[k];
            r_sq_zero[k+1] <= r_sq_zero[k];
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {r_sq_m[32][i], 30'd0} + {31'd0, r_sq_root[32][31:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_sq_vld[32];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= {1'b0, n_num[i][61:31]};
            r_dv_low[0][i] <= n_num[i][30:0];
        end
        r_dv_quo[0]  <= '0;
        r_dv_len[0]  <= r_sq_root[32];
        r_dv_neg[0]  <= r_sq_neg[32];
        r_dv_zero[0] <= r_sq_zero[32];
        r_dv_side[0] <= r_sq_side[32];
    end

    for (genvar k = 0; k < 31; k++) begin : g_div
        logic [2:0][32:0] w_cur;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_cur[i] = {r_dv_rem[k][i], r_dv_low[k][i][30]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (w_cur[i] >= {1'b0, r_dv_len[k]}) begin
                    r_dv_rem[k+1][i] <= 32'(w_cur[i] - {1'b0, r_dv_len[k]});
                    r_dv_quo[k+1][i] <= {r_dv_quo[k][i][29:0], 1'b1};
                end else begin
                    r_dv_rem[k+1][i] <= w_cur[i][31:0];
                    r_dv_quo[k+1][i] <= {r_dv_quo[k][i][29:0], 1'b0};
                end
                r_dv_low[k+1][i] <= {r_dv_low[k][i][29:0], 1'b0};
            end
            r_dv_len[k+1]  <= r_dv_len[k];
            r_dv_neg[k+1]  <= r_dv_neg[k];
            r_dv_zero[k+1] <= r_dv_zero[k];
            r_dv_side[k+1] <= r_dv_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv_vld[31];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[31]) begin
                r_out_unit[i] <= '0;
            end else if (r_dv_neg[31][i]) begin
                r_out_unit[i] <= 32'd0 - {1'b0, r_dv_quo[31][i]};
            end else begin
                r_out_unit[i] <= {1'b0, r_dv_quo[31][i]};
            end
        end
        r_out_side <= r_dv_side[31];
    end

    assign o_valid = r_out_vld;
    assign o_unit  = r_out_unit;
    assign o_side  = r_out_side;

endmodule

// ----- rtl/core/lavm_xlate.sv -----
`timescale 1ns / 1ps

module lavm_xlate (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lavm_pkg::t_vec3  i_row_x,
    input  lavm_pkg::t_vec3  i_row_y,
    input  lavm_pkg::t_vec3  i_row_z,
    input  lavm_pkg::t_vec3  i_pos,
    output logic             o_valid,
    output lavm_pkg::t_vec3  o_row_x,
    output lavm_pkg::t_vec3  o_row_y,
    output lavm_pkg::t_vec3  o_row_z,
    output logic [2:0][31:0] o_trans
);
    import lavm_pkg::*;

    logic                     r1_vld, r2_vld, r3_vld;
    logic signed [63:0]       r1_prod [3][3];
    t_vec3                    r1_rows [3];
    t_vec3                    r2_rows [3];
    t_vec3                    r3_rows [3];
    logic signed [65:0]       r2_sum  [3];
    logic [2:0][31:0]         r3_trans;

    logic signed [65:0]       n_neg   [3];
    logic signed [35:0]       n_round [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_neg[r]   = (66'sd0 - r2_sum[r]) + 66'sd536870912;
            n_round[r] = 36'(n_neg[r] >>> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r1_prod[0][j] <= $signed(i_row_x[j]) * $signed(i_pos[j]);
            r1_prod[1][j] <= $signed(i_row_y[j]) * $signed(i_pos[j]);
            r1_prod[2][j] <= $signed(i_row_z[j]) * $signed(i_pos[j]);
        end
        r1_rows[0] <= i_row_x;
        r1_rows[1] <= i_row_y;
        r1_rows[2] <= i_row_z;

        for (int r = 0; r < 3; r++) begin
            r2_sum[r] <= 66'(r1_prod[r][0]) + 66'(r1_prod[r][1]) + 66'(r1_prod[r][2]);
        end
        r2_rows <= r1_rows;

        for (int r = 0; r < 3; r++) begin
            if (n_round[r] > 36'sd2147483647) begin
                r3_trans[r] <= 32'h7FFF_FFFF;
            end else if (n_round[r] < -36'sd2147483648) begin
                r3_trans[r] <= 32'h8000_0000;
            end else begin
                r3_trans[r] <= n_round[r][31:0];
            end
        end
        r3_rows <= r2_rows;
    end

    assign o_valid = r3_vld;
    assign o_row_x = r3_rows[0];
    assign o_row_y = r3_rows[1];
    assign o_row_z = r3_rows[2];
    assign o_trans = r3_trans;

endmodule

// ----- rtl/core/look_at_view_matrix_core.sv -----
`timescale 1ns / 1ps
// Accepts one camera in every cycle; busy is always low.
// The path from start to o_valid runs through the input difference register, three
// normalizers of 70 stages each (32-stage square root and 31-stage divider), two
// 2-stage cross units and a 3-stage translation unit.
// Synchronous active-low reset clears only the valid pipeline; the receiver cannot stall.
module look_at_view_matrix_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_upvec_x,
    input  logic [31:0] i_upvec_y,
    input  logic [31:0] i_upvec_z,
    output logic        o_valid,
    output logic [31:0] o_m00,
    output logic [31:0] o_m01,
    output logic [31:0] o_m02,
    output logic [31:0] o_m03,
    output logic [31:0] o_m10,
    output logic [31:0] o_m11,
    output logic [31:0] o_m12,
    output logic [31:0] o_m13,
    output logic [31:0] o_m20,
    output logic [31:0] o_m21,
    output logic [31:0] o_m22,
    output logic [31:0] o_m23
);
    import lavm_pkg::*;

    localparam int TOTAL_LAT = 1 + 3 * NORM_LAT + 2 * CROSS_LAT + XLATE_LAT;

    logic             r_vld;
    t_wvec3           r_diff;
    t_vec3            r_pos;
    t_vec3            r_up;

    logic             w_z_vld, w_c1_vld, w_x_vld, w_c2_vld, w_y_vld, w_o_vld;
    t_vec3            w_z, w_x, w_y;
    t_vec3            w_z_up, w_z_pos, w_c1_z, w_c1_pos, w_x_z, w_x_pos;
    t_vec3            w_c2_x, w_c2_z, w_c2_pos, w_y_x, w_y_z, w_y_pos;
    t_wvec3           w_c1, w_c2;
    t_vec3            w_ox, w_oy, w_oz;
    logic [2:0][31:0] w_trans;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff[0] <= 64'($signed({i_pos_x[31], i_pos_x}) - $signed({i_target_x[31], i_target_x}));
        r_diff[1] <= 64'($signed({i_pos_y[31], i_pos_y}) - $signed({i_target_y[31], i_target_y}));
        r_diff[2] <= 64'($signed({i_pos_z[31], i_pos_z}) - $signed({i_target_z[31], i_target_z}));
        r_pos     <= {i_pos_z, i_pos_y, i_pos_x};
        r_up      <= {i_upvec_z, i_upvec_y, i_upvec_x};
    end

    lavm_norm #(.SIDE_W(192)) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld),
        .i_vec   (r_diff),
        .i_side  ({r_up, r_pos}),
        .o_valid (w_z_vld),
        .o_unit  (w_z),
        .o_side  ({w_z_up, w_z_pos})
    );

    lavm_cross #(.SIDE_W(192)) u_cross_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_z_vld),
        .i_a     (w_z_up),
        .i_b     (w_z),
        .i_side  ({w_z, w_z_pos}),
        .o_valid (w_c1_vld),
        .o_c     (w_c1),
        .o_side  ({w_c1_z, w_c1_pos})
    );

    lavm_norm #(.SIDE_W(192)) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c1_vld),
        .i_vec   (w_c1),
        .i_side  ({w_c1_z, w_c1_pos}),
        .o_valid (w_x_vld),
        .o_unit  (w_x),
        .o_side  ({w_x_z, w_x_pos})
    );

    lavm_cross #(.SIDE_W(288)) u_cross_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_x_vld),
        .i_a     (w_x_z),
        .i_b     (w_x),
        .i_side  ({w_x, w_x_z, w_x_pos}),
        .o_valid (w_c2_vld),
        .o_c     (w_c2),
        .o_side  ({w_c2_x, w_c2_z, w_c2_pos})
    );

    lavm_norm #(.SIDE_W(288)) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c2_vld),
        .i_vec   (w_c2),
        .i_side  ({w_c2_x, w_c2_z, w_c2_pos}),
        .o_valid (w_y_vld),
        .o_unit  (w_y),
        .o_side  ({w_y_x, w_y_z, w_y_pos})
    );

    lavm_xlate u_xlate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_y_vld),
        .i_row_x (w_y_x),
        .i_row_y (w_y),
        .i_row_z (w_y_z),
        .i_pos   (w_y_pos),
        .o_valid (w_o_vld),
        .o_row_x (w_ox),
        .o_row_y (w_oy),
        .o_row_z (w_oz),
        .o_trans (w_trans)
    );

    assign o_valid = w_o_vld;
    assign o_m00   = w_ox[0];
    assign o_m01   = w_ox[1];
    assign o_m02   = w_ox[2];
    assign o_m03   = w_trans[0];
    assign o_m10   = w_oy[0];
    assign o_m11   = w_oy[1];
    assign o_m12   = w_oy[2];
    assign o_m13   = w_trans[1];
    assign o_m20   = w_oz[0];
    assign o_m21   = w_oz[1];
    assign o_m22   = w_oz[2];
    assign o_m23   = w_trans[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##TOTAL_LAT o_valid)
        else $error("accepted word did not leave after the pipeline latency");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_m00) <= 32'sd1073741824 && $signed(o_m00) >= -32'sd1073741824
                  && $signed(o_m22) <= 32'sd1073741824 && $signed(o_m22) >= -32'sd1073741824))
        else $error("unit axis component out of range");

    a_zero_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_m20 == 32'd0 && o_m21 == 32'd0 && o_m22 == 32'd0)
        |-> (o_m00 == 32'd0 && o_m01 == 32'd0 && o_m02 == 32'd0 && o_m23 == 32'd0))
        else $error("zero back axis gave a nonzero side axis");

    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

// ----- tb/look_at_view_matrix_checker.sv -----
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_upvec_x,
    input  logic [31:0] i_upvec_y,
    input  logic [31:0] i_upvec_z,
    input  logic        o_valid,
    input  logic [31:0] o_m00,
    input  logic [31:0] o_m01,
    input  logic [31:0] o_m02,
    input  logic [31:0] o_m03,
    input  logic [31:0] o_m10,
    input  logic [31:0] o_m11,
    input  logic [31:0] o_m12,
    input  logic [31:0] o_m13,
    input  logic [31:0] o_m20,
    input  logic [31:0] o_m21,
    input  logic [31:0] o_m22,
    input  logic [31:0] o_m23,
    output int          o_fail_count,
    output int          o_pending
);

    typedef logic [11:0][31:0] t_matrix;

    t_matrix matrix_queue[$];

    function automatic logic [63:0] root_floor(input logic [63:0] s_in);
        logic [63:0] s;
        logic [63:0] res;
        logic [63:0] b;
        s = s_in;
        res = '0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vector(input longint v[3], output longint n[3]);
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? 64'd0 - 64'(v[i]) : 64'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 0;
            return;
        end
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
        len = root_floor(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            n[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_product(input longint a[3], input longint b[3],
                                          output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [31:0] translation(input longint row[3], input longint p[3]);
        longint sum;
        longint r;
        logic [63:0] u;
        sum = row[0] * p[0] + row[1] * p[1] + row[2] * p[2];
        u = 64'(-sum) + (64'd1 << 29) + (64'd1 << 63);
        r = longint'(u >> 30) - (longint'(1) << 33);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_matrix view_matrix(input logic [8:0][31:0] cam);
        longint p[3];
        longint up[3];
        longint d[3];
        longint xa[3];
        longint ya[3];
        longint za[3];
        longint t[3];
        t_matrix mat;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'(signed'(cam[i]));
            d[i] = p[i] - longint'(signed'(cam[3 + i]));
            up[i] = longint'(signed'(cam[6 + i]));
        end
        unit_vector(d, za);
        cross_product(up, za, t);
        unit_vector(t, xa);
        cross_product(za, xa, t);
        unit_vector(t, ya);
        for (int j = 0; j < 3; j++) begin
            mat[j] = xa[j][31:0];
            mat[4 + j] = ya[j][31:0];
            mat[8 + j] = za[j][31:0];
        end
        mat[3] = translation(xa, p);
        mat[7] = translation(ya, p);
        mat[11] = translation(za, p);
        return mat;
    endfunction

    assign o_pending = matrix_queue.size();

    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (start && !busy) begin
                matrix_queue.push_back(view_matrix({i_upvec_z, i_upvec_y, i_upvec_x,
                    i_target_z, i_target_y, i_target_x, i_pos_z, i_pos_y, i_pos_x}));
            end
            if (o_valid) begin
                got = {o_m23, o_m22, o_m21, o_m20, o_m13, o_m12, o_m11, o_m10,
                       o_m03, o_m02, o_m01, o_m00};
                if (matrix_queue.size() == 0) begin
                    $display("%0t: matrix word with none expected", $time);
                    errs = errs + 1;
                end else begin
                    want = matrix_queue.pop_front();
                    for (int k = 0; k < 12; k++) begin
                        if (got[k] !== want[k]) begin
                            $display("%0t: m%0d%0d expected %h actual %h", $time,
                                     k / 4, k % 4, want[k], got[k]);
                            errs = errs + 1;
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ----- tb/look_at_view_matrix_core_tb.sv -----
`timescale 1ns / 1ps

module look_at_view_matrix_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [8:0][31:0] cam = '0;
    logic        o_valid;
    logic [11:0][31:0] mat;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    always #2 i_clk = ~i_clk;

    look_at_view_matrix_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(cam[0]), .i_pos_y(cam[1]), .i_pos_z(cam[2]),
        .i_target_x(cam[3]), .i_target_y(cam[4]), .i_target_z(cam[5]),
        .i_upvec_x(cam[6]), .i_upvec_y(cam[7]), .i_upvec_z(cam[8]),
        .o_valid(o_valid),
        .o_m00(mat[0]), .o_m01(mat[1]), .o_m02(mat[2]), .o_m03(mat[3]),
        .o_m10(mat[4]), .o_m11(mat[5]), .o_m12(mat[6]), .o_m13(mat[7]),
        .o_m20(mat[8]), .o_m21(mat[9]), .o_m22(mat[10]), .o_m23(mat[11])
    );

    look_at_view_matrix_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(cam[0]), .i_pos_y(cam[1]), .i_pos_z(cam[2]),
        .i_target_x(cam[3]), .i_target_y(cam[4]), .i_target_z(cam[5]),
        .i_upvec_x(cam[6]), .i_upvec_y(cam[7]), .i_upvec_z(cam[8]),
        .o_valid(o_valid),
        .o_m00(mat[0]), .o_m01(mat[1]), .o_m02(mat[2]), .o_m03(mat[3]),
        .o_m10(mat[4]), .o_m11(mat[5]), .o_m12(mat[6]), .o_m13(mat[7]),
        .o_m20(mat[8]), .o_m21(mat[9]), .o_m22(mat[10]), .o_m23(mat[11]),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) << 8;
        endcase
    endfunction

    task automatic send_camera(input logic [8:0][31:0] c, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        cam <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random(input bit gaps);
        logic [8:0][31:0] c;
        for (int i = 0; i < 9; i++) c[i] = rand_coord();
        case ($urandom_range(0, 9))
            0: c[5:3] = c[2:0];
            1: c[8:6] = '0;
            2: for (int i = 0; i < 3; i++) c[6 + i] = c[i] - c[3 + i];
            3: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i] - c[i];
            default: ;
        endcase
        send_camera(c, gaps);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed cameras: standard view, extremes, degenerate axes.
        send_camera({32'd0, 32'h10000, 32'd0, 32'd0, 32'd0, 32'd0,
                     32'h50000, 32'd0, 32'd0}, 1'b0);
        send_camera('0, 1'b0);
        send_camera({9{32'h7FFFFFFF}}, 1'b0);
        send_camera({9{32'h80000000}}, 1'b0);
        send_camera({{3{32'h7FFFFFFF}}, {3{32'h80000000}}, {3{32'h7FFFFFFF}}}, 1'b0);
        send_camera({{3{32'h80000000}}, {3{32'h7FFFFFFF}}, {3{32'h80000000}}}, 1'b0);
        send_camera({32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000}, 1'b0);
        send_camera({32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1}, 1'b0);
        send_camera({32'd0, 32'h10000, 32'd0, 32'd0, 32'h20000, 32'd0,
                     32'd0, 32'd0, 32'd0}, 1'b0);
        send_camera({32'd0, 32'd0, 32'd0, 32'h1234, 32'h5678, 32'h9ABC,
                     32'h1234, 32'h5678, 32'h9ABC}, 1'b0);
        send_camera({32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b0);
        send_camera({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF}, 1'b0);
        for (int i = 0; i < 6; i++) send_random(1'b1);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        for (int i = 0; i < 400; i++) send_random(1'b0);
        for (int i = 0; i < 1330; i++) send_random(1'b1);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lavm_pkg.sv
rtl/core/lavm_cross.sv
rtl/core/lavm_norm.sv
rtl/core/lavm_xlate.sv
rtl/core/look_at_view_matrix_core.sv
tb/look_at_view_matrix_checker.sv
tb/look_at_view_matrix_core_tb.sv
